[rtl/core/hid_report_frame_deframer_unit_macros.svh]
// Assertion macros for the HID report frame deframer.
// Used by the port checker; needs nothing else.
`ifndef HID_REPORT_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define HID_REPORT_FRAME_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define HRFD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrfd assertion failed");

// next-cycle implication, held off during reset
`define HRFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrfd assertion failed");

`endif

[rtl/core/hrfd_pkg.sv]
// Shared types and constants of the HID report frame deframer.
// No dependencies.
`default_nettype none

package hrfd_pkg;

   localparam int unsigned BUFFER_BYTES_DEFAULT = 128;
   localparam int unsigned KEY_COUNT_DEFAULT    = 6;
   localparam int unsigned NUM_KEYS             = 6;
   localparam int unsigned FIELD_DEPTH          = 8;
   localparam int unsigned FIELD_BASE           = 3;
   localparam int unsigned KEY_BASE             = 2;
   localparam int unsigned FRAME_OVERHEAD       = 4;
   localparam int unsigned QUEUE_DEPTH          = 2;

   localparam logic [7:0] SYNC_RESET     = 8'hA5;
   localparam logic [7:0] KEYBOARD_RESET = 8'h4B;
   localparam logic [7:0] MOUSE_RESET    = 8'h4D;

   typedef enum logic [1:0] {
      CSR_SYNC     = 2'd0,
      CSR_KEYBOARD = 2'd1,
      CSR_MOUSE    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_KEYBOARD = 3'd0,
      ST_MOUSE    = 3'd1,
      ST_OTHER    = 3'd2,
      ST_CHECKSUM = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef struct packed {
      status_type                  status;
      logic                        sent;
      logic [7:0]                  plen;
      logic [FIELD_DEPTH-1:0][7:0] field;
   } frame_desc_type;

endpackage

`default_nettype wire

[rtl/core/hrfd_front.sv]
// Front end: config registers, sync hunt, byte count, checksum and frame classification.
// Depends on hrfd_pkg.
`default_nettype none

module hrfd_front #(
   parameter int unsigned BUFFER_BYTES = hrfd_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   input  wire logic [1:0]               csr_index,
   input  wire logic [7:0]               csr_wdata,
   input  wire logic                     push,
   input  wire logic                     full,
   input  wire logic [7:0]               rx_byte,
   input  wire logic                     host_ready,
   output logic                          desc_push,
   output hrfd_pkg::frame_desc_type      desc
);

   localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
   localparam int unsigned EW = (CW > 9) ? CW : 9;
   localparam int unsigned FW = $clog2(hrfd_pkg::FIELD_DEPTH);

   logic [7:0] sync_ff, sync_in;
   logic [7:0] kbd_ff, kbd_in;
   logic [7:0] mouse_ff, mouse_in;

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    kind_ff, kind_in;
   logic [7:0]    plen_ff, plen_in;
   logic [7:0]    sum_ff, sum_in;
   logic [hrfd_pkg::FIELD_DEPTH-1:0][7:0] field_ff, field_in;

   logic          accept;
   logic [CW-1:0] cnt_next;
   logic [FW-1:0] fidx;
   logic          done;
   logic          ovf;

   assign accept   = push & ~full;
   assign cnt_next = count_ff + CW'(1);
   assign fidx     = FW'(count_ff - CW'(hrfd_pkg::FIELD_BASE));

   always_comb begin
      sync_in  = sync_ff;
      kbd_in   = kbd_ff;
      mouse_in = mouse_ff;
      if (csr_valid) begin
         unique case (hrfd_pkg::csr_index_type'(csr_index))
            hrfd_pkg::CSR_SYNC:     sync_in  = csr_wdata;
            hrfd_pkg::CSR_KEYBOARD: kbd_in   = csr_wdata;
            hrfd_pkg::CSR_MOUSE:    mouse_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      count_in  = count_ff;
      kind_in   = kind_ff;
      plen_in   = plen_ff;
      sum_in    = sum_ff;
      field_in  = field_ff;
      done      = 1'b0;
      ovf       = 1'b0;
      desc_push = 1'b0;
      if (accept) begin
         if (count_ff == '0) begin
            if (rx_byte == sync_ff) begin
               field_in = '0;
               sum_in   = '0;
               count_in = CW'(1);
            end
         end else begin
            sum_in   = sum_ff + rx_byte;
            count_in = cnt_next;
            if (count_ff == CW'(1)) begin
               kind_in = rx_byte;
            end else if (count_ff == CW'(2)) begin
               plen_in = rx_byte;
            end else if (count_ff >= CW'(hrfd_pkg::FIELD_BASE) &&
                         count_ff < CW'(hrfd_pkg::FIELD_BASE + hrfd_pkg::FIELD_DEPTH)) begin
               field_in[fidx] = rx_byte;
            end
            if (cnt_next >= CW'(3)) begin
               if (EW'(cnt_next) == EW'(plen_in) + EW'(hrfd_pkg::FRAME_OVERHEAD)) begin
                  done = 1'b1;
               end else if (cnt_next >= CW'(BUFFER_BYTES)) begin
                  ovf = 1'b1;
               end
            end
            if (done || ovf) begin
               count_in  = '0;
               desc_push = 1'b1;
            end
         end
      end
   end

   always_comb begin
      priority if (ovf) begin
         desc.status = hrfd_pkg::ST_OVERFLOW;
      end else if (sum_in != 8'd0) begin
         desc.status = hrfd_pkg::ST_CHECKSUM;
      end else if (kind_in == kbd_ff) begin
         desc.status = hrfd_pkg::ST_KEYBOARD;
      end else if (kind_in == mouse_ff) begin
         desc.status = hrfd_pkg::ST_MOUSE;
      end else begin
         desc.status = hrfd_pkg::ST_OTHER;
      end
      desc.sent  = host_ready && (desc.status == hrfd_pkg::ST_KEYBOARD ||
                                  desc.status == hrfd_pkg::ST_MOUSE);
      desc.plen  = plen_in;
      desc.field = field_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff  <= hrfd_pkg::SYNC_RESET;
         kbd_ff   <= hrfd_pkg::KEYBOARD_RESET;
         mouse_ff <= hrfd_pkg::MOUSE_RESET;
         count_ff <= '0;
      end else begin
         sync_ff  <= sync_in;
         kbd_ff   <= kbd_in;
         mouse_ff <= mouse_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      plen_ff  <= plen_in;
      sum_ff   <= sum_in;
      field_ff <= field_in;
   end

endmodule

`default_nettype wire

[rtl/core/hrfd_queue.sv]
// Short descriptor queue between the front end and the result stage.
// Depends on hrfd_pkg.
`default_nettype none

module hrfd_queue #(
   parameter int unsigned DEPTH = hrfd_pkg::QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire hrfd_pkg::frame_desc_type wdata,
   output logic                          full,
   output logic                          rd_valid,
   input  wire logic                     pop,
   output hrfd_pkg::frame_desc_type      rdata
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned NW = $clog2(DEPTH + 1);

   hrfd_pkg::frame_desc_type mem_ff [DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic          do_push;
   logic          do_pop;

   assign full     = (fill_ff == NW'(DEPTH));
   assign rd_valid = (fill_ff != '0);
   assign rdata    = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

[rtl/core/hrfd_back.sv]
// Result stage: decodes a frame descriptor into report fields and holds the output item.
// Depends on hrfd_pkg.
`default_nettype none

module hrfd_back #(
   parameter int unsigned KEY_COUNT = hrfd_pkg::KEY_COUNT_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                desc_valid,
   input  wire hrfd_pkg::frame_desc_type            desc,
   output logic                                     desc_pop,
   input  wire logic                                pop,
   output logic                                     empty,
   output logic [2:0]                               frame_status,
   output logic                                     report_sent,
   output logic [7:0]                               modifier_or_buttons,
   output logic [hrfd_pkg::NUM_KEYS-1:0][7:0]       key_codes,
   output logic signed [7:0]                        mouse_dx,
   output logic signed [7:0]                        mouse_dy
);

   logic valid_ff, valid_in;
   logic load;

   logic [2:0]                         status_ff, status_in;
   logic                               sent_ff, sent_in;
   logic [7:0]                         mod_ff, mod_in;
   logic [hrfd_pkg::NUM_KEYS-1:0][7:0] keys_ff, keys_in;
   logic [7:0]                         dx_ff, dx_in;
   logic [7:0]                         dy_ff, dy_in;

   logic is_kbd;
   logic is_mouse;

   assign load     = desc_valid & (~valid_ff | pop);
   assign desc_pop = load;
   assign valid_in = load ? 1'b1 : (pop ? 1'b0 : valid_ff);
   assign is_kbd   = (desc.status == hrfd_pkg::ST_KEYBOARD);
   assign is_mouse = (desc.status == hrfd_pkg::ST_MOUSE);

   always_comb begin
      status_in = desc.status;
      sent_in   = desc.sent;
      mod_in    = (is_kbd || is_mouse) ? desc.field[0] : 8'd0;
      dx_in     = is_mouse ? desc.field[1] : 8'd0;
      dy_in     = is_mouse ? desc.field[2] : 8'd0;
      for (int k = 0; k < hrfd_pkg::NUM_KEYS; k++) begin
         keys_in[k] = (is_kbd && k < KEY_COUNT && 8'(k) < desc.plen) ?
                      desc.field[hrfd_pkg::KEY_BASE + k] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         sent_ff   <= sent_in;
         mod_ff    <= mod_in;
         keys_ff   <= keys_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
      end
   end

   assign empty               = ~valid_ff;
   assign frame_status        = status_ff;
   assign report_sent         = sent_ff;
   assign modifier_or_buttons = mod_ff;
   assign key_codes           = keys_ff;
   assign mouse_dx            = dx_ff;
   assign mouse_dy            = dy_ff;

endmodule

`default_nettype wire

[rtl/core/hid_report_frame_deframer_unit.sv]
// HID report frame deframer, top level: front end, descriptor queue, result stage.
// Depends on hrfd_pkg, hrfd_front, hrfd_queue, hrfd_back.
//
// Usage:
//  Input queue side: one serial byte per item on req_rx_byte with req_host_ready,
//  taken when push is high and full is low; one byte per cycle while full is low.
//  Result queue side: one item per finished or abandoned frame (keyboard, mouse,
//  other valid type, checksum fail, overflow). While empty is low the oldest item
//  is on rsp_*; pop takes it.
//  Path: a frame's result passes the descriptor queue, then the output register,
//  to rsp_*. Bytes that do not end a frame produce nothing.
//  Config: csr_valid/csr_ready with csr_index (0 sync, 1 keyboard type, 2 mouse
//  type) and csr_wdata; csr_ready is always high. Write only while idle.
//  Reset: config returns to 0xA5 / 'K' / 'M', the parser hunts for sync, both
//  queues are emptied.
//  Stall: while pop is low the result holds; frame results build up in a
//  two-entry queue, and full rises once it and the output register are taken.
`default_nettype none

module hid_report_frame_deframer_unit #(
   parameter int unsigned BUFFER_BYTES = hrfd_pkg::BUFFER_BYTES_DEFAULT,
   parameter int unsigned KEY_COUNT    = hrfd_pkg::KEY_COUNT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_host_ready,
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_frame_status,
   output logic             rsp_report_sent,
   output logic [7:0]       rsp_modifier_or_buttons,
   output logic [7:0]       rsp_key_code_0,
   output logic [7:0]       rsp_key_code_1,
   output logic [7:0]       rsp_key_code_2,
   output logic [7:0]       rsp_key_code_3,
   output logic [7:0]       rsp_key_code_4,
   output logic [7:0]       rsp_key_code_5,
   output logic signed [7:0] rsp_mouse_dx,
   output logic signed [7:0] rsp_mouse_dy
);

   hrfd_pkg::frame_desc_type           front_desc;
   hrfd_pkg::frame_desc_type           queue_desc;
   logic                               front_push;
   logic                               queue_full;
   logic                               queue_valid;
   logic                               queue_pop;
   logic [hrfd_pkg::NUM_KEYS-1:0][7:0] key_codes;

   assign csr_ready = 1'b1;
   assign full      = queue_full;

   hrfd_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .full       (queue_full),
      .rx_byte    (req_rx_byte),
      .host_ready (req_host_ready),
      .desc_push  (front_push),
      .desc       (front_desc)
   );

   hrfd_queue #(
      .DEPTH(hrfd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .wdata    (front_desc),
      .full     (queue_full),
      .rd_valid (queue_valid),
      .pop      (queue_pop),
      .rdata    (queue_desc)
   );

   hrfd_back #(
      .KEY_COUNT(KEY_COUNT)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .desc_valid          (queue_valid),
      .desc                (queue_desc),
      .desc_pop            (queue_pop),
      .pop                 (pop),
      .empty               (empty),
      .frame_status        (rsp_frame_status),
      .report_sent         (rsp_report_sent),
      .modifier_or_buttons (rsp_modifier_or_buttons),
      .key_codes           (key_codes),
      .mouse_dx            (rsp_mouse_dx),
      .mouse_dy            (rsp_mouse_dy)
   );

   assign rsp_key_code_0 = key_codes[0];
   assign rsp_key_code_1 = key_codes[1];
   assign rsp_key_code_2 = key_codes[2];
   assign rsp_key_code_3 = key_codes[3];
   assign rsp_key_code_4 = key_codes[4];
   assign rsp_key_code_5 = key_codes[5];

endmodule

`default_nettype wire

[rtl/core/hrfd_checker.sv]
// Port-level checker for the HID report frame deframer, bound to the top level.
// Depends on hrfd_pkg and hid_report_frame_deframer_unit_macros.svh.
`default_nettype none

`include "hid_report_frame_deframer_unit_macros.svh"

module hrfd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              empty,
   input wire logic              pop,
   input wire logic [2:0]        rsp_frame_status,
   input wire logic              rsp_report_sent,
   input wire logic [7:0]        rsp_modifier_or_buttons,
   input wire logic [7:0]        rsp_key_code_0,
   input wire logic signed [7:0] rsp_mouse_dx,
   input wire logic signed [7:0] rsp_mouse_dy
);

   logic        is_report;
   logic        is_plain;
   logic        is_kbd;
   logic        no_motion;
   logic        plain_zero;
   logic        stalled;
   logic [10:0] head_bits;

   assign is_report  = (rsp_frame_status == hrfd_pkg::ST_KEYBOARD) ||
                       (rsp_frame_status == hrfd_pkg::ST_MOUSE);
   assign is_plain   = (rsp_frame_status == hrfd_pkg::ST_OTHER) ||
                       (rsp_frame_status == hrfd_pkg::ST_CHECKSUM) ||
                       (rsp_frame_status == hrfd_pkg::ST_OVERFLOW);
   assign is_kbd     = (rsp_frame_status == hrfd_pkg::ST_KEYBOARD);
   assign no_motion  = (rsp_mouse_dx == 8'sd0) && (rsp_mouse_dy == 8'sd0);
   assign plain_zero = (rsp_modifier_or_buttons == 8'd0) && (rsp_key_code_0 == 8'd0) &&
                       no_motion;
   assign stalled    = !empty && !pop;
   assign head_bits  = {rsp_frame_status, rsp_modifier_or_buttons};

   `HRFD_ASSERT_IMPLIES(a_sent_only_report, clock, reset, !empty && rsp_report_sent, is_report)

   `HRFD_ASSERT_IMPLIES(a_plain_no_data, clock, reset, !empty && is_plain, plain_zero)

   `HRFD_ASSERT_IMPLIES(a_kbd_no_motion, clock, reset, !empty && is_kbd, no_motion)

   `HRFD_ASSERT_NEXT(a_stall_keeps_item, clock, reset, stalled, !empty)

   `HRFD_ASSERT_NEXT(a_stall_holds, clock, reset, stalled, $stable(head_bits))

endmodule

bind hid_report_frame_deframer_unit hrfd_checker u_hrfd_checker (
   .clock                   (clock),
   .reset                   (reset),
   .empty                   (empty),
   .pop                     (pop),
   .rsp_frame_status        (rsp_frame_status),
   .rsp_report_sent         (rsp_report_sent),
   .rsp_modifier_or_buttons (rsp_modifier_or_buttons),
   .rsp_key_code_0          (rsp_key_code_0),
   .rsp_mouse_dx            (rsp_mouse_dx),
   .rsp_mouse_dy            (rsp_mouse_dy)
);

`default_nettype wire
